### hdl/pds_pkg.sv
// ---------------------------------------------------------------------------
// pds_pkg: shared types and constants for PID differential steering
// Field widths, fixed-point format, register indexes, datapath commands and
// the rounding and saturation helpers used by the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package pds_pkg;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int INTEG_W        = 32;
  localparam int ERR_W          = 9;
  localparam int DIFF_W         = ERR_W + 1;
  localparam int CFG_W          = 16;
  localparam int BASE_W         = 8;
  localparam int POWER_W        = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int POWER_LIMIT    = 100;

  // shared multiplier: CFG_W x INTEG_W
  localparam int PROD_W  = CFG_W + INTEG_W;
  localparam int TRUNC_W = PROD_W - GAIN_FRAC_BITS;
  localparam int ACC_W   = TRUNC_W + 2;
  localparam int SUM_W   = TRUNC_W + 1;

  localparam logic signed [CFG_W-1:0]  RST_GAIN_P   = CFG_W'(256);
  localparam logic signed [CFG_W-1:0]  RST_GAIN_I   = CFG_W'(0);
  localparam logic signed [CFG_W-1:0]  RST_GAIN_D   = CFG_W'(0);
  localparam logic signed [CFG_W-1:0]  RST_UPPER    = CFG_W'(100);
  localparam logic signed [CFG_W-1:0]  RST_LOWER    = CFG_W'(-100);
  localparam logic signed [BASE_W-1:0] RST_BASE     = BASE_W'(50);
  localparam logic signed [CFG_W-1:0]  RST_LEFT_SC  = CFG_W'(-256);
  localparam logic signed [CFG_W-1:0]  RST_RIGHT_SC = CFG_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_UPPER       = 3'd3,
    REG_LOWER       = 3'd4,
    REG_BASE        = 3'd5,
    REG_LEFT_SCALE  = 3'd6,
    REG_RIGHT_SCALE = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_I = 2'd1,
    MUL_D = 2'd2,
    MUL_S = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load;      // capture input, update integral and previous error
    logic     mul_en;    // register product of selected operands
    mul_sel_t mul_sel;
    logic     acc_clr;
    logic     acc_add;   // add truncated product into accumulator
    logic     clamp_en;  // clamp accumulator into control value
    logic     out_load;  // load powers into output register
  } pds_cmd_t;

  // product shifted down by the fraction bits, rounded toward zero
  function automatic logic signed [TRUNC_W-1:0] fix_trunc(
      input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] bias;
    logic [PROD_W-1:0] adj;
    bias = {{(PROD_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{p[PROD_W-1]}}};
    adj  = p + bias;
    return adj[PROD_W-1:GAIN_FRAC_BITS];
  endfunction

  function automatic logic signed [POWER_W-1:0] sat_power(
      input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(POWER_LIMIT);
    lo = SUM_W'(-POWER_LIMIT);
    if (v > hi) begin
      return POWER_W'(POWER_LIMIT);
    end else if (v < lo) begin
      return POWER_W'(-POWER_LIMIT);
    end
    return v[POWER_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/pds_in_if.sv
// ---------------------------------------------------------------------------
// pds_in_if: input channel
// Brightness error and traced edge side with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface pds_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pds_pkg::ERR_W-1:0]    brightness_error;
  logic                                edge_side;

  modport source (output valid, output brightness_error, output edge_side,
                  input ready);
  modport sink   (input valid, input brightness_error, input edge_side,
                  output ready);
endinterface

`default_nettype wire

### hdl/pds_out_if.sv
// ---------------------------------------------------------------------------
// pds_out_if: result channel
// Left and right motor powers with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface pds_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pds_pkg::POWER_W-1:0]  left_power;
  logic signed [pds_pkg::POWER_W-1:0]  right_power;

  modport source (output valid, output left_power, output right_power,
                  input ready);
  modport sink   (input valid, input left_power, input right_power,
                  output ready);
endinterface

`default_nettype wire

### hdl/pds_dp.sv
// ---------------------------------------------------------------------------
// pds_dp: PID steering datapath
// Config registers, error state, trapezoid integral, shared multiplier,
// accumulator, control clamp and output power register.
// ---------------------------------------------------------------------------
`default_nettype none

module pds_dp (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire                                       cfg_we,
  input  wire [pds_pkg::CFG_IDX_W-1:0]              cfg_idx,
  input  wire [pds_pkg::CFG_W-1:0]                  cfg_data,
  input  wire signed [pds_pkg::ERR_W-1:0]           in_err,
  input  wire                                       in_side,
  input  pds_pkg::pds_cmd_t                         cmd,
  output logic signed [pds_pkg::POWER_W-1:0]        left_power,
  output logic signed [pds_pkg::POWER_W-1:0]        right_power
);

  localparam int EW = pds_pkg::ERR_W;
  localparam int DW = pds_pkg::DIFF_W;
  localparam int IW = pds_pkg::INTEG_W;
  localparam int CW = pds_pkg::CFG_W;
  localparam int BW = pds_pkg::BASE_W;
  localparam int PW = pds_pkg::PROD_W;
  localparam int TW = pds_pkg::TRUNC_W;
  localparam int AW = pds_pkg::ACC_W;
  localparam int SW = pds_pkg::SUM_W;

  // configuration
  logic signed [CW-1:0] gain_p_r, gain_i_r, gain_d_r, upper_r, lower_r;
  logic signed [CW-1:0] left_sc_r, right_sc_r;
  logic signed [BW-1:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r   <= pds_pkg::RST_GAIN_P;
      gain_i_r   <= pds_pkg::RST_GAIN_I;
      gain_d_r   <= pds_pkg::RST_GAIN_D;
      upper_r    <= pds_pkg::RST_UPPER;
      lower_r    <= pds_pkg::RST_LOWER;
      base_r     <= pds_pkg::RST_BASE;
      left_sc_r  <= pds_pkg::RST_LEFT_SC;
      right_sc_r <= pds_pkg::RST_RIGHT_SC;
    end else if (cfg_we) begin
      case (pds_pkg::reg_idx_t'(cfg_idx))
        pds_pkg::REG_GAIN_P:      gain_p_r   <= cfg_data;
        pds_pkg::REG_GAIN_I:      gain_i_r   <= cfg_data;
        pds_pkg::REG_GAIN_D:      gain_d_r   <= cfg_data;
        pds_pkg::REG_UPPER:       upper_r    <= cfg_data;
        pds_pkg::REG_LOWER:       lower_r    <= cfg_data;
        pds_pkg::REG_BASE:        base_r     <= cfg_data[BW-1:0];
        pds_pkg::REG_LEFT_SCALE:  left_sc_r  <= cfg_data;
        pds_pkg::REG_RIGHT_SCALE: right_sc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // error state and integral
  logic signed [EW-1:0] prev_r, e_r;
  logic signed [DW-1:0] diff_r;
  logic signed [IW-1:0] integ_r;
  logic                 side_r;

  logic signed [DW-1:0] pair_sum, pair_adj, diff_nxt;
  logic signed [EW-1:0] half;
  logic signed [IW:0]   integ_sum;
  logic signed [IW-1:0] integ_nxt;

  always_comb begin
    pair_sum = {in_err[EW-1], in_err} + {prev_r[EW-1], prev_r};
    // halve toward zero: bias negative sums by one before the shift
    pair_adj = pair_sum + {{(DW-1){1'b0}}, pair_sum[DW-1]};
    half     = EW'(pair_adj >>> 1);
    diff_nxt = {in_err[EW-1], in_err} - {prev_r[EW-1], prev_r};
    integ_sum = {integ_r[IW-1], integ_r} + {{(IW+1-EW){half[EW-1]}}, half};
    if (integ_sum[IW] != integ_sum[IW-1]) begin
      integ_nxt = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      integ_nxt = integ_sum[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      integ_r <= '0;
    end else if (cmd.load) begin
      prev_r  <= in_err;
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_r    <= in_err;
      diff_r <= diff_nxt;
      side_r <= in_side;
    end
  end

  // shared multiplier
  logic signed [CW-1:0] mul_a;
  logic signed [IW-1:0] mul_b;
  logic signed [PW-1:0] prod_nxt, prod_r;
  logic signed [CW-1:0] u_r;

  always_comb begin
    case (cmd.mul_sel)
      pds_pkg::MUL_P: begin
        mul_a = gain_p_r;
        mul_b = {{(IW-EW){e_r[EW-1]}}, e_r};
      end
      pds_pkg::MUL_I: begin
        mul_a = gain_i_r;
        mul_b = integ_r;
      end
      pds_pkg::MUL_D: begin
        mul_a = gain_d_r;
        mul_b = {{(IW-DW){diff_r[DW-1]}}, diff_r};
      end
      pds_pkg::MUL_S: begin
        mul_a = side_r ? right_sc_r : left_sc_r;
        mul_b = {{(IW-CW){u_r[CW-1]}}, u_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // accumulate P + I + D, then clamp
  logic signed [TW-1:0] prod_t;
  logic signed [AW-1:0] acc_r, upper_x, lower_x;

  always_comb begin
    prod_t  = pds_pkg::fix_trunc(prod_r);
    upper_x = {{(AW-CW){upper_r[CW-1]}}, upper_r};
    lower_x = {{(AW-CW){lower_r[CW-1]}}, lower_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {{(AW-TW){prod_t[TW-1]}}, prod_t};
    end
  end

  // upper test first, so crossed limits favor upper above it
  always_ff @(posedge clk) begin
    if (cmd.clamp_en) begin
      if (acc_r > upper_x) begin
        u_r <= upper_r;
      end else if (acc_r < lower_x) begin
        u_r <= lower_r;
      end else begin
        u_r <= acc_r[CW-1:0];
      end
    end
  end

  // powers
  logic signed [SW-1:0] base_x, s_x;

  always_comb begin
    base_x = {{(SW-BW){base_r[BW-1]}}, base_r};
    s_x    = {prod_t[TW-1], prod_t};
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      left_power  <= pds_pkg::sat_power(base_x + s_x);
      right_power <= pds_pkg::sat_power(base_x - s_x);
    end
  end

endmodule

`default_nettype wire

### hdl/pds_ctrl.sv
// ---------------------------------------------------------------------------
// pds_ctrl: PID steering sequencer
// One-hot state machine stepping the datapath through one tick and owning
// the input ready and output valid flags.
// ---------------------------------------------------------------------------
`default_nettype none

module pds_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 out_ready,
  output logic                out_valid,
  output pds_pkg::pds_cmd_t   cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MP    = 8'b0000_0010,
    ST_MI    = 8'b0000_0100,
    ST_MD    = 8'b0000_1000,
    ST_ACC   = 8'b0001_0000,
    ST_CLAMP = 8'b0010_0000,
    ST_MS    = 8'b0100_0000,
    ST_FINAL = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MP;
        end
      end
      ST_MP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pds_pkg::MUL_P;
        cmd.acc_clr = 1'b1;
        state_nxt   = ST_MI;
      end
      ST_MI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pds_pkg::MUL_I;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_MD;
      end
      ST_MD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pds_pkg::MUL_D;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp_en = 1'b1;
        state_nxt    = ST_MS;
      end
      ST_MS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pds_pkg::MUL_S;
        state_nxt   = ST_FINAL;
      end
      ST_FINAL: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input taken while a tick is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten before transfer");

  a_load_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !cmd.load && !cmd.out_load)
    else $error("tick sequence skipped");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> $past(state_r == ST_MS) || $past(state_r == ST_FINAL))
    else $error("output loaded outside final step");

endmodule

`default_nettype wire

### hdl/pid_differential_steering.sv
// ---------------------------------------------------------------------------
// pid_differential_steering: PID line steering for a differential drive
// Trapezoid-integral PID on a brightness error, clamped, scaled by the
// traced edge gain and split into saturated left/right motor powers.
// ---------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_chan   in   valid/ready      brightness_error[8:0] s, edge_side
//  out_chan  out  valid/ready      left_power[7:0] s, right_power[7:0] s
//  cfg_*     in   cfg_we strobe    cfg_idx[2:0], cfg_data[15:0]
//
//  A tick runs from transfer back to ready through four products on one
//  shared 16x32 multiplier, plus clamp and output steps.
//  A finished result sits in the output register; the next tick is taken
//  while it waits, and completes once the register is free.
//  Synchronous active-low reset restores register defaults and clears the
//  integral and previous error.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_differential_steering (
  input  wire                              clk,
  input  wire                              rst_n,
  pds_in_if.sink                           in_chan,
  pds_out_if.source                        out_chan,
  input  wire                              cfg_we,
  input  wire [pds_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire [pds_pkg::CFG_W-1:0]         cfg_data
);

  pds_pkg::pds_cmd_t cmd;
  logic              in_ready;
  logic              out_valid;

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pds_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .in_err      (in_chan.brightness_error),
    .in_side     (in_chan.edge_side),
    .cmd         (cmd),
    .left_power  (out_chan.left_power),
    .right_power (out_chan.right_power)
  );

endmodule

`default_nettype wire

### test/pid_differential_steering_tb.sv
// ---------------------------------------------------------------------------
// pid_differential_steering_tb: self-checking bench for PID steering
// Drives brightness error samples through the input channel under random
// idling and a long output stall, mirrors the register file and the PID
// state in a scoreboard, and compares every left/right power pair with the
// predicted one across directed corner settings and random settings.
// ---------------------------------------------------------------------------

typedef struct packed {
  logic signed [pds_pkg::POWER_W-1:0] left_power;
  logic signed [pds_pkg::POWER_W-1:0] right_power;
} power_pair_t;

class steering_scoreboard;
  logic signed [pds_pkg::CFG_W-1:0]  gain_p, gain_i, gain_d;
  logic signed [pds_pkg::CFG_W-1:0]  upper, lower, left_scale, right_scale;
  logic signed [pds_pkg::BASE_W-1:0] base_power;
  longint      last_error;
  longint      integral;
  power_pair_t pending[$];
  int          errors;
  int          reported;
  int          checked;

  function new();
    gain_p      = pds_pkg::RST_GAIN_P;
    gain_i      = pds_pkg::RST_GAIN_I;
    gain_d      = pds_pkg::RST_GAIN_D;
    upper       = pds_pkg::RST_UPPER;
    lower       = pds_pkg::RST_LOWER;
    base_power  = pds_pkg::RST_BASE;
    left_scale  = pds_pkg::RST_LEFT_SC;
    right_scale = pds_pkg::RST_RIGHT_SC;
    last_error  = 0;
    integral    = 0;
    errors      = 0;
    reported    = 0;
    checked     = 0;
  endfunction

  function void write_reg(pds_pkg::reg_idx_t idx, logic [pds_pkg::CFG_W-1:0] data);
    case (idx)
      pds_pkg::REG_GAIN_P:      gain_p      = data;
      pds_pkg::REG_GAIN_I:      gain_i      = data;
      pds_pkg::REG_GAIN_D:      gain_d      = data;
      pds_pkg::REG_UPPER:       upper       = data;
      pds_pkg::REG_LOWER:       lower       = data;
      pds_pkg::REG_BASE:        base_power  = data[pds_pkg::BASE_W-1:0];
      pds_pkg::REG_LEFT_SCALE:  left_scale  = data;
      pds_pkg::REG_RIGHT_SCALE: right_scale = data;
      default: ;
    endcase
  endfunction

  // Q8.8 product, rounded toward zero
  function longint q8_mul(longint g, longint x);
    return (g * x) / (longint'(1) << pds_pkg::GAIN_FRAC_BITS);
  endfunction

  function logic signed [pds_pkg::POWER_W-1:0] motor_sat(longint v);
    if (v > pds_pkg::POWER_LIMIT) return pds_pkg::POWER_W'(pds_pkg::POWER_LIMIT);
    if (v < -pds_pkg::POWER_LIMIT) return pds_pkg::POWER_W'(-pds_pkg::POWER_LIMIT);
    return v[pds_pkg::POWER_W-1:0];
  endfunction

  function void note_input(logic signed [pds_pkg::ERR_W-1:0] err, logic side);
    longint      e, q, int_max, int_min, u, s;
    power_pair_t pair;
    e       = err;
    q       = last_error;
    int_max = (longint'(1) << (pds_pkg::INTEG_W - 1)) - 1;
    int_min = -int_max - 1;
    integral = integral + (e + q) / 2;
    if (integral > int_max) integral = int_max;
    else if (integral < int_min) integral = int_min;
    u = q8_mul(gain_p, e) + q8_mul(gain_i, integral) + q8_mul(gain_d, e - q);
    // upper test first, so crossed limits favor upper above it
    if (u > upper) u = upper;
    else if (u < lower) u = lower;
    s = q8_mul(u, side ? right_scale : left_scale);
    pair.left_power  = motor_sat(base_power + s);
    pair.right_power = motor_sat(base_power - s);
    pending.push_back(pair);
    last_error = e;
  endfunction

  function void check_result(logic signed [pds_pkg::POWER_W-1:0] l,
                             logic signed [pds_pkg::POWER_W-1:0] r);
    power_pair_t want;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("unexpected power pair #%0d: L=%0d R=%0d", checked, l, r);
      end
      return;
    end
    want = pending.pop_front();
    if (want.left_power !== l || want.right_power !== r) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("power pair #%0d mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                 checked, want.left_power, want.right_power, l, r);
      end
    end
  endfunction
endclass

module pid_differential_steering_tb;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_CYCLES     = 300;
  localparam int TICK_LATENCY    = 8;
  localparam int IDLE_PCT        = 18;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 198;

  localparam int STYLE_TYPICAL = 0;
  localparam int STYLE_RANDOM  = 1;
  localparam int STYLE_CORNER  = 2;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [pds_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [pds_pkg::CFG_W-1:0]     cfg_data;

  pds_in_if  in_if ();
  pds_out_if out_if ();

  pid_differential_steering dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  steering_scoreboard        sb;
  logic [pds_pkg::CFG_W-1:0] settings [1 << pds_pkg::CFG_IDX_W];
  bit                        steady;
  bit                        hold_off_req;
  int                        samples_sent;
  int                        settings_loaded;
  int                        idle_cycles;

  always #5 clk = ~clk;

  task automatic send_item(input int err_value, input logic side);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.brightness_error <= pds_pkg::ERR_W'(err_value);
    in_if.edge_side        <= side;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(pds_pkg::ERR_W'(err_value), side);
    samples_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TICK_LATENCY) @(posedge clk);
  endtask

  task automatic load_settings();
    wait_idle();
    for (int k = 0; k < $size(settings); k++) begin
      @(negedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= pds_pkg::CFG_IDX_W'(k);
      cfg_data <= settings[k];
      sb.write_reg(pds_pkg::reg_idx_t'(k), settings[k]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  function automatic logic [pds_pkg::CFG_W-1:0] pick_value(input int style,
                                                           input int span);
    if (style == STYLE_RANDOM) return pds_pkg::CFG_W'($urandom);
    if (style == STYLE_CORNER) begin
      case ($urandom_range(0, 4))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'h0000;
        3:       return 16'h0001;
        default: return 16'hFFFF;
      endcase
    end
    return pds_pkg::CFG_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // result side: checked at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result(out_if.left_power, out_if.right_power);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: cycles without any transfer
  initial begin
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int   style;
    int   track;
    int   err;
    int   mode;
    logic side;

    clk                    = 1'b0;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = '0;
    cfg_data               = '0;
    in_if.valid            = 1'b0;
    in_if.brightness_error = '0;
    in_if.edge_side        = 1'b0;
    out_if.ready           = 1'b0;
    steady                 = 1'b0;
    hold_off_req           = 1'b0;
    samples_sent           = 0;
    settings_loaded        = 0;
    track                  = 0;
    side                   = 1'b0;
    sb = new();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults, field extremes on both edges
    send_item(0, 1'b0);
    send_item(255, 1'b0);
    send_item(255, 1'b1);
    send_item(-255, 1'b1);
    send_item(-256, 1'b0);
    send_item(1, 1'b1);
    send_item(-1, 1'b0);
    send_item(100, 1'b1);

    // every register at its extreme
    settings[pds_pkg::REG_GAIN_P]      = 16'h7FFF;
    settings[pds_pkg::REG_GAIN_I]      = 16'h8000;
    settings[pds_pkg::REG_GAIN_D]      = 16'h7FFF;
    settings[pds_pkg::REG_UPPER]       = 16'h7FFF;
    settings[pds_pkg::REG_LOWER]       = 16'h8000;
    settings[pds_pkg::REG_BASE]        = 16'h007F;
    settings[pds_pkg::REG_LEFT_SCALE]  = 16'h8000;
    settings[pds_pkg::REG_RIGHT_SCALE] = 16'h7FFF;
    load_settings();
    send_item(255, 1'b0);
    send_item(-256, 1'b1);
    send_item(-255, 1'b0);
    send_item(255, 1'b1);
    send_item(0, 1'b0);
    send_item(-256, 1'b0);

    // crossed clamp limits, most negative base power
    settings[pds_pkg::REG_GAIN_P]      = 16'd256;
    settings[pds_pkg::REG_GAIN_I]      = 16'd16;
    settings[pds_pkg::REG_GAIN_D]      = pds_pkg::CFG_W'(-512);
    settings[pds_pkg::REG_UPPER]       = pds_pkg::CFG_W'(-50);
    settings[pds_pkg::REG_LOWER]       = 16'd50;
    settings[pds_pkg::REG_BASE]        = 16'hFF80;
    settings[pds_pkg::REG_LEFT_SCALE]  = 16'd256;
    settings[pds_pkg::REG_RIGHT_SCALE] = pds_pkg::CFG_W'(-256);
    load_settings();
    send_item(200, 1'b0);
    send_item(-200, 1'b1);
    send_item(0, 1'b0);
    send_item(10, 1'b1);
    send_item(-10, 1'b0);
    send_item(255, 1'b1);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      style = phase % 3;
      settings[pds_pkg::REG_GAIN_P]      = pick_value(style, 768);
      settings[pds_pkg::REG_GAIN_I]      = pick_value(style, 32);
      settings[pds_pkg::REG_GAIN_D]      = pick_value(style, 1024);
      settings[pds_pkg::REG_UPPER]       = pick_value(style, 300);
      settings[pds_pkg::REG_LOWER]       = pick_value(style, 300);
      settings[pds_pkg::REG_BASE]        = pick_value(style, 100);
      settings[pds_pkg::REG_LEFT_SCALE]  = pick_value(style, 512);
      settings[pds_pkg::REG_RIGHT_SCALE] = pick_value(style, 512);
      steady = (phase == 3);
      load_settings();
      if (phase == 5) hold_off_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
          err = int'($urandom_range(0, 511));
        end else if (mode < 9) begin
          // slowly wandering error, like a sensor drifting across the edge
          track = track + int'($urandom_range(0, 32)) - 16;
          if (track > 255) track = 255;
          if (track < -256) track = -256;
          err = track;
        end else begin
          case ($urandom_range(0, 3))
            0:       err = 255;
            1:       err = -255;
            2:       err = -256;
            default: err = 0;
          endcase
        end
        if ($urandom_range(0, 9) == 0) side = ~side;
        send_item(err, side);
      end
    end
    steady = 1'b0;
    wait_idle();

    $display("Covered %0d error samples and %0d power pairs over %0d register settings,",
             samples_sent, sb.checked, settings_loaded);
    $display("with extreme gains and clamps, crossed limits and a %0d-cycle output stall.",
             HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results still expected", sb.errors, sb.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
